// ----- rtl/core/mrrp_pkg.sv -----
// ----------------------------------------------------------------------------
// mrrp_pkg
// Shared constants, codes, control structs and helper functions for the
// multi-reader ring pointer manager.
// ----------------------------------------------------------------------------
package mrrp_pkg;

   localparam int RING_BYTES  = 4096;
   localparam int NUM_READERS = 8;

   // fixed field widths
   localparam int FUNC_W = 3;
   localparam int SLOT_W = 3;
   localparam int CNT_W  = 13;
   localparam int OFS_W  = 12;
   localparam int STAT_W = 3;

   localparam int IDX_W = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;

   // command codes
   localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
   localparam logic [FUNC_W-1:0] FN_ACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_PEEK = 3'd2;
   localparam logic [FUNC_W-1:0] FN_DUP  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_REM  = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd1;
   localparam logic [STAT_W-1:0] ST_TOO_BIG  = 3'd2;
   localparam logic [STAT_W-1:0] ST_BAD_SLOT = 3'd3;
   localparam logic [STAT_W-1:0] ST_LAST     = 3'd4;

   localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(RING_BYTES);

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic scan;
      logic pop;
      logic load_rsp;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_pop;
      logic scan_done;
   } dp_stat_type;

   // capacity write: clamp into 1..RING_BYTES
   function automatic logic [CNT_W-1:0] cap_sat(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (v > CAP_MAX) begin
         r = CAP_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // bytes a reader can still read; head and start are always below cap
   function automatic logic [CNT_W-1:0] readable_calc(
      input logic [OFS_W-1:0] head,
      input logic             starved,
      input logic [OFS_W-1:0] start,
      input logic [CNT_W-1:0] used,
      input logic [CNT_W-1:0] cap
   );
      logic [CNT_W-1:0] d;
      logic [CNT_W-1:0] r;
      if (head >= start) begin
         d = {1'b0, head} - {1'b0, start};
      end else begin
         d = {1'b0, head} + cap - {1'b0, start};
      end
      if (head == start && starved && used >= cap) begin
         r = '0;
      end else if (d > used) begin
         r = '0;
      end else begin
         r = used - d;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/multi_reader_ring_pointers.sv -----
// ----------------------------------------------------------------------------
// multi_reader_ring_pointers
// Pointer manager for a byte ring shared by several independent readers.
// ----------------------------------------------------------------------------
// One command word in, one result word out. Push, peek, duplicate and an ack
// that does not move the oldest reader pass through accept, execute and
// result load. An ack by the reader sitting at the ring start, and a
// successful remove, add a scan over all reader slots, one slot per cycle,
// and then a release step before the result load. The result sits in an
// output register, so the sequencer finishes a word while the previous
// result still waits on rsp_stall; a new command is taken only once the
// current one has been loaded out. Writing the capacity register clears
// the ring (start, fill, heads, starved flags) but keeps the active slots;
// write it only while no command is in flight.
// ----------------------------------------------------------------------------
module multi_reader_ring_pointers (
   input  logic                        clock,
   input  logic                        reset,
   // command channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mrrp_pkg::FUNC_W-1:0] req_func,
   input  logic [mrrp_pkg::SLOT_W-1:0] req_reader,
   input  logic [mrrp_pkg::SLOT_W-1:0] req_source_reader,
   input  logic [mrrp_pkg::CNT_W-1:0]  req_count,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mrrp_pkg::STAT_W-1:0] rsp_status,
   output logic [mrrp_pkg::CNT_W-1:0]  rsp_readable,
   output logic [mrrp_pkg::OFS_W-1:0]  rsp_offset,
   output logic [mrrp_pkg::CNT_W-1:0]  rsp_used_bytes,
   // capacity register
   input  logic                        csr_wr_en,
   input  logic [mrrp_pkg::CNT_W-1:0]  csr_wr_data
);

   mrrp_pkg::ctl_cmd_type cmd;
   mrrp_pkg::dp_stat_type stat;

   // sequencer
   mrrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // pointers, slots, scan and output register
   mrrp_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_reader        (req_reader),
      .req_source_reader (req_source_reader),
      .req_count         (req_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_status        (rsp_status),
      .rsp_readable      (rsp_readable),
      .rsp_offset        (rsp_offset),
      .rsp_used_bytes    (rsp_used_bytes)
   );

endmodule

// ----- rtl/core/mrrp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrrp_ctrl
// Command sequencer: accept, execute, optional reader scan and release,
// then result load into the output register.
// ----------------------------------------------------------------------------
module mrrp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  mrrp_pkg::dp_stat_type stat,
   output mrrp_pkg::ctl_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_POP  = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = stat.need_pop ? S_SCAN : S_RESP;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_EXEC))
      else $error("accepted word did not enter execute");

   a_scan_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && !stat.scan_done) |=> (state_ff == S_SCAN))
      else $error("reader scan left early");

endmodule

// ----- rtl/core/mrrp_dpath.sv -----
// ----------------------------------------------------------------------------
// mrrp_dpath
// Ring pointers, reader slots, command registers, scan unit and output
// register.
// ----------------------------------------------------------------------------
module mrrp_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  mrrp_pkg::ctl_cmd_type           cmd,
   output mrrp_pkg::dp_stat_type           stat,
   input  logic [mrrp_pkg::FUNC_W-1:0]     req_func,
   input  logic [mrrp_pkg::SLOT_W-1:0]     req_reader,
   input  logic [mrrp_pkg::SLOT_W-1:0]     req_source_reader,
   input  logic [mrrp_pkg::CNT_W-1:0]      req_count,
   input  logic                            csr_wr_en,
   input  logic [mrrp_pkg::CNT_W-1:0]      csr_wr_data,
   output logic [mrrp_pkg::STAT_W-1:0]     rsp_status,
   output logic [mrrp_pkg::CNT_W-1:0]      rsp_readable,
   output logic [mrrp_pkg::OFS_W-1:0]      rsp_offset,
   output logic [mrrp_pkg::CNT_W-1:0]      rsp_used_bytes
);

   localparam int N = mrrp_pkg::NUM_READERS;

   // ring and reader state
   logic [mrrp_pkg::CNT_W-1:0] cap_ff, cap_in;
   logic [mrrp_pkg::OFS_W-1:0] start_ff, start_in;
   logic [mrrp_pkg::CNT_W-1:0] used_ff, used_in;
   logic [mrrp_pkg::OFS_W-1:0] head_ff [N];
   logic [mrrp_pkg::OFS_W-1:0] head_in [N];
   logic [N-1:0]               starved_ff, starved_in;
   logic [N-1:0]               active_ff, active_in;

   // command word
   logic [mrrp_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [mrrp_pkg::SLOT_W-1:0] rd_ff, rd_in;
   logic [mrrp_pkg::SLOT_W-1:0] src_ff, src_in;
   logic [mrrp_pkg::CNT_W-1:0]  count_ff, count_in;

   // working regs
   logic [mrrp_pkg::STAT_W-1:0] status_ff, status_in;
   logic [mrrp_pkg::OFS_W-1:0]  tail_ff, tail_in;
   logic [mrrp_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [mrrp_pkg::CNT_W-1:0]  max_ff, max_in;

   // output register
   logic [mrrp_pkg::STAT_W-1:0] o_status_ff, o_status_in;
   logic [mrrp_pkg::CNT_W-1:0]  o_readable_ff, o_readable_in;
   logic [mrrp_pkg::OFS_W-1:0]  o_offset_ff, o_offset_in;
   logic [mrrp_pkg::CNT_W-1:0]  o_used_ff, o_used_in;

   // slot decode
   logic [mrrp_pkg::IDX_W-1:0] rd_idx, src_idx, rp_addr;
   logic                       rd_ok, src_ok, rd_range;
   logic [mrrp_pkg::OFS_W-1:0] head_rp;
   logic                       starved_rp;
   logic [mrrp_pkg::CNT_W-1:0] readable_rp;

   // arithmetic
   logic [mrrp_pkg::CNT_W-1:0] tail_sum, used_sum, head_sum, room;
   logic [mrrp_pkg::OFS_W-1:0] head_new;
   logic [mrrp_pkg::CNT_W-1:0] keep, drop, start_sum;

   assign rd_idx   = mrrp_pkg::IDX_W'(rd_ff);
   assign src_idx  = mrrp_pkg::IDX_W'(src_ff);
   assign rd_range = (int'(rd_ff) < N);
   assign rd_ok    = rd_range && active_ff[rd_idx];
   assign src_ok   = (int'(src_ff) < N) && active_ff[src_idx];

   // single read port on the reader table
   always_comb begin
      if (cmd.scan) begin
         rp_addr = idx_ff;
      end else if (cmd.execute && func_ff == mrrp_pkg::FN_DUP) begin
         rp_addr = src_idx;
      end else begin
         rp_addr = rd_idx;
      end
   end

   assign head_rp     = head_ff[rp_addr];
   assign starved_rp  = starved_ff[rp_addr];
   assign readable_rp = mrrp_pkg::readable_calc(head_rp, starved_rp, start_ff,
                                                used_ff, cap_ff);

   // wrap helpers; each sum stays below twice the capacity wherever it is used
   assign tail_sum = {1'b0, start_ff} + used_ff;
   assign room     = cap_ff - used_ff;
   assign used_sum = used_ff + count_ff;
   assign head_sum = {1'b0, head_rp} + count_ff;
   assign head_new = (head_sum >= cap_ff) ? mrrp_pkg::OFS_W'(head_sum - cap_ff)
                                          : mrrp_pkg::OFS_W'(head_sum);
   assign keep      = (max_ff > used_ff) ? used_ff : max_ff;
   assign drop      = used_ff - keep;
   assign start_sum = {1'b0, start_ff} + drop;

   // release runs after an ack by the reader at the ring start, or a successful remove;
   // scan ends on the last slot
   always_comb begin
      stat.scan_done = (idx_ff == mrrp_pkg::IDX_W'(N - 1));
      stat.need_pop  = 1'b0;
      case (func_ff)
         mrrp_pkg::FN_ACK: begin
            stat.need_pop = rd_ok && count_ff <= readable_rp && count_ff != '0
                            && head_rp == start_ff;
         end
         mrrp_pkg::FN_REM: begin
            stat.need_pop = rd_ok && ($countones(active_ff) > 1);
         end
         default: begin
            stat.need_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      cap_in        = cap_ff;
      start_in      = start_ff;
      used_in       = used_ff;
      head_in       = head_ff;
      starved_in    = starved_ff;
      active_in     = active_ff;
      func_in       = func_ff;
      rd_in         = rd_ff;
      src_in        = src_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      tail_in       = tail_ff;
      idx_in        = idx_ff;
      max_in        = max_ff;
      o_status_in   = o_status_ff;
      o_readable_in = o_readable_ff;
      o_offset_in   = o_offset_ff;
      o_used_in     = o_used_ff;

      if (cmd.capture) begin
         func_in  = req_func;
         rd_in    = req_reader;
         src_in   = req_source_reader;
         count_in = req_count;
      end

      if (cmd.execute) begin
         status_in = mrrp_pkg::ST_OK;
         idx_in    = '0;
         max_in    = '0;
         case (func_ff)
            mrrp_pkg::FN_PUSH: begin
               tail_in = (tail_sum >= cap_ff) ? mrrp_pkg::OFS_W'(tail_sum - cap_ff)
                                              : mrrp_pkg::OFS_W'(tail_sum);
               if (count_ff > room) begin
                  status_in = mrrp_pkg::ST_NO_SPACE;
               end else if (count_ff != '0) begin
                  used_in = used_sum;
                  if (used_sum == cap_ff) begin
                     starved_in = '0;
                  end
               end
            end
            mrrp_pkg::FN_ACK: begin
               if (!rd_ok) begin
                  status_in = mrrp_pkg::ST_BAD_SLOT;
               end else if (count_ff > readable_rp) begin
                  status_in = mrrp_pkg::ST_TOO_BIG;
               end else if (count_ff != '0) begin
                  head_in[rd_idx] = head_new;
                  if (head_new == start_ff) begin
                     starved_in[rd_idx] = 1'b1;
                  end
               end
            end
            mrrp_pkg::FN_PEEK: begin
               if (!rd_ok) begin
                  status_in = mrrp_pkg::ST_BAD_SLOT;
               end
            end
            mrrp_pkg::FN_DUP: begin
               if (!rd_range || active_ff[rd_idx] || !src_ok) begin
                  status_in = mrrp_pkg::ST_BAD_SLOT;
               end else begin
                  head_in[rd_idx]    = head_rp;
                  starved_in[rd_idx] = starved_rp;
                  active_in[rd_idx]  = 1'b1;
               end
            end
            mrrp_pkg::FN_REM: begin
               if (!rd_ok) begin
                  status_in = mrrp_pkg::ST_BAD_SLOT;
               end else if ($countones(active_ff) <= 1) begin
                  status_in = mrrp_pkg::ST_LAST;
               end else begin
                  active_in[rd_idx] = 1'b0;
               end
            end
            default: begin
               status_in = mrrp_pkg::ST_BAD_SLOT;
            end
         endcase
      end

      // one reader per cycle into the running max
      if (cmd.scan) begin
         if (active_ff[idx_ff] && readable_rp > max_ff) begin
            max_in = readable_rp;
         end
         idx_in = idx_ff + mrrp_pkg::IDX_W'(1);
      end

      if (cmd.pop) begin
         used_in  = keep;
         start_in = (start_sum >= cap_ff) ? mrrp_pkg::OFS_W'(start_sum - cap_ff)
                                          : mrrp_pkg::OFS_W'(start_sum);
      end

      if (cmd.load_rsp) begin
         o_status_in   = status_ff;
         o_readable_in = rd_ok ? readable_rp : '0;
         if (func_ff == mrrp_pkg::FN_PUSH) begin
            o_offset_in = tail_ff;
         end else begin
            o_offset_in = rd_ok ? head_rp : '0;
         end
         o_used_in = used_ff;
      end

      // capacity write empties the ring, slots stay
      if (csr_wr_en) begin
         cap_in     = mrrp_pkg::cap_sat(csr_wr_data);
         start_in   = '0;
         used_in    = '0;
         starved_in = '0;
         for (int i = 0; i < N; i++) begin
            head_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= mrrp_pkg::CAP_MAX;
         start_ff   <= '0;
         used_ff    <= '0;
         starved_ff <= '0;
         active_ff  <= N'(1);
         for (int i = 0; i < N; i++) begin
            head_ff[i] <= '0;
         end
      end else begin
         cap_ff     <= cap_in;
         start_ff   <= start_in;
         used_ff    <= used_in;
         starved_ff <= starved_in;
         active_ff  <= active_in;
         head_ff    <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      rd_ff         <= rd_in;
      src_ff        <= src_in;
      count_ff      <= count_in;
      status_ff     <= status_in;
      tail_ff       <= tail_in;
      idx_ff        <= idx_in;
      max_ff        <= max_in;
      o_status_ff   <= o_status_in;
      o_readable_ff <= o_readable_in;
      o_offset_ff   <= o_offset_in;
      o_used_ff     <= o_used_in;
   end

   assign rsp_status     = o_status_ff;
   assign rsp_readable   = o_readable_ff;
   assign rsp_offset     = o_offset_ff;
   assign rsp_used_bytes = o_used_ff;

   a_used_fits: assert property (@(posedge clock) disable iff (reset)
      used_ff <= cap_ff)
      else $error("ring fill exceeds capacity");

   a_start_fits: assert property (@(posedge clock) disable iff (reset)
      {1'b0, start_ff} < cap_ff)
      else $error("ring start outside capacity");

   a_one_reader: assert property (@(posedge clock) disable iff (reset)
      active_ff != '0)
      else $error("no active reader left");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking regression for multi_reader_ring_pointers. A cycle-free
// model of the ring pointers predicts each result word at command accept.
// Directed corner cases, then randomized phases across many capacities,
// plus a long result hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT   = 600_000;  // several times the slowest legal run
   localparam int SETTLE_CYCLES = 16;       // covers accept, execute, slot scan, release and result load
   localparam int HOLD_CYCLES   = 400;      // long result hold-off
   localparam int PHASE_WORDS   = 137;      // random words per capacity phase
   localparam int NOISE_PCT     = 15;       // share of malformed or stray words
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [mrrp_pkg::STAT_W-1:0] status;
      logic [mrrp_pkg::CNT_W-1:0]  readable;
      logic [mrrp_pkg::OFS_W-1:0]  offset;
      logic [mrrp_pkg::CNT_W-1:0]  used_bytes;
   } ring_reply_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_type;

   // ------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic                        clock             = 1'b0;
   logic                        reset             = 1'b1;
   logic                        req_valid         = 1'b0;
   logic                        req_stall;
   logic [mrrp_pkg::FUNC_W-1:0] req_func          = mrrp_pkg::FN_PEEK;
   logic [mrrp_pkg::SLOT_W-1:0] req_reader        = '0;
   logic [mrrp_pkg::SLOT_W-1:0] req_source_reader = '0;
   logic [mrrp_pkg::CNT_W-1:0]  req_count         = '0;
   logic                        rsp_valid;
   logic                        rsp_stall         = 1'b0;
   logic [mrrp_pkg::STAT_W-1:0] rsp_status;
   logic [mrrp_pkg::CNT_W-1:0]  rsp_readable;
   logic [mrrp_pkg::OFS_W-1:0]  rsp_offset;
   logic [mrrp_pkg::CNT_W-1:0]  rsp_used_bytes;
   logic                        csr_wr_en         = 1'b0;
   logic [mrrp_pkg::CNT_W-1:0]  csr_wr_data       = '0;

   multi_reader_ring_pointers dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_reader        (req_reader),
      .req_source_reader (req_source_reader),
      .req_count         (req_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_readable      (rsp_readable),
      .rsp_offset        (rsp_offset),
      .rsp_used_bytes    (rsp_used_bytes),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Ring pointer model: our own copy of capacity, start, fill and the
   // per-slot head / starved / active bits.
   // ------------------------------------------------------------------
   logic [mrrp_pkg::CNT_W-1:0] ring_cap;
   logic [mrrp_pkg::OFS_W-1:0] ring_start;
   logic [mrrp_pkg::CNT_W-1:0] ring_fill;
   logic [mrrp_pkg::OFS_W-1:0] head_of    [mrrp_pkg::NUM_READERS];
   logic                       starved_of [mrrp_pkg::NUM_READERS];
   logic                       live_of    [mrrp_pkg::NUM_READERS];

   ring_reply_type ring_replies [$];  // result words owed by the block, oldest first

   // run bookkeeping
   int  words_sent     = 0;
   int  words_checked  = 0;
   int  mismatches     = 0;
   int  caps_written   = 0;
   int  burst_left     = 0;
   bit  sender_idles   = 1'b1;
   bit  hold_request   = 1'b0;
   logic hold_on       = 1'b0;
   int  cycle_count    = 0;
   int  status_seen [8];

   function automatic void empty_ring();
      int r;
      ring_start = '0;
      ring_fill  = '0;
      for (r = 0; r < mrrp_pkg::NUM_READERS; r++) begin
         head_of[r]    = '0;
         starved_of[r] = 1'b0;
      end
   endfunction

   function automatic bit slot_live(input int r);
      return (r < mrrp_pkg::NUM_READERS) && live_of[r];
   endfunction

   // bytes slot r can still read; full ring with head at start is the
   // ambiguous spot, resolved by the starved flag
   function automatic int unsigned reach_of(input int r);
      int unsigned c, h, s, d;
      c = 32'(ring_cap);
      h = head_of[r] % c;
      s = ring_start % c;
      d = (h + c - s) % c;
      if (h == s && starved_of[r] && ring_fill >= c) return 0;
      if (d > ring_fill) return 0;
      return ring_fill - d;
   endfunction

   // drop bytes behind every live reader
   function automatic void free_unreachable();
      int unsigned top, n;
      int r;
      top = 0;
      for (r = 0; r < mrrp_pkg::NUM_READERS; r++)
         if (live_of[r] && reach_of(r) > top) top = reach_of(r);
      if (top > ring_fill) top = ring_fill;
      n          = ring_fill - top;
      ring_fill  = mrrp_pkg::CNT_W'(top);
      ring_start = mrrp_pkg::OFS_W'((ring_start + n) % ring_cap);
   endfunction

   // apply one command to the model and return the word the block owes
   function automatic ring_reply_type apply_ring_cmd(
      input logic [mrrp_pkg::FUNC_W-1:0] fn,
      input logic [mrrp_pkg::SLOT_W-1:0] rd,
      input logic [mrrp_pkg::SLOT_W-1:0] src,
      input logic [mrrp_pkg::CNT_W-1:0]  cnt
   );
      ring_reply_type rep;
      int unsigned c, tail, nlive;
      bit at_start;
      int r;
      c          = 32'(ring_cap);
      rep        = '0;
      rep.status = mrrp_pkg::ST_OK;
      tail       = (ring_start + ring_fill) % c;
      case (fn)
         mrrp_pkg::FN_PUSH: begin
            if (cnt > c - ring_fill) begin
               rep.status = mrrp_pkg::ST_NO_SPACE;
            end else if (cnt != 0) begin
               ring_fill = mrrp_pkg::CNT_W'(ring_fill + cnt);
               if (ring_fill == c)
                  for (r = 0; r < mrrp_pkg::NUM_READERS; r++) starved_of[r] = 1'b0;
            end
         end
         mrrp_pkg::FN_ACK: begin
            if (!slot_live(rd)) begin
               rep.status = mrrp_pkg::ST_BAD_SLOT;
            end else if (cnt > reach_of(rd)) begin
               rep.status = mrrp_pkg::ST_TOO_BIG;
            end else if (cnt != 0) begin
               at_start    = (head_of[rd] % c) == (ring_start % c);
               head_of[rd] = mrrp_pkg::OFS_W'((head_of[rd] % c + cnt) % c);
               if (head_of[rd] == ring_start % c) starved_of[rd] = 1'b1;
               if (at_start) free_unreachable();
            end
         end
         mrrp_pkg::FN_PEEK: begin
            if (!slot_live(rd)) rep.status = mrrp_pkg::ST_BAD_SLOT;
         end
         mrrp_pkg::FN_DUP: begin
            if (int'(rd) >= mrrp_pkg::NUM_READERS || live_of[rd] || !slot_live(src)) begin
               rep.status = mrrp_pkg::ST_BAD_SLOT;
            end else begin
               head_of[rd]    = head_of[src];
               starved_of[rd] = starved_of[src];
               live_of[rd]    = 1'b1;
            end
         end
         mrrp_pkg::FN_REM: begin
            if (!slot_live(rd)) begin
               rep.status = mrrp_pkg::ST_BAD_SLOT;
            end else begin
               nlive = 0;
               for (r = 0; r < mrrp_pkg::NUM_READERS; r++) if (live_of[r]) nlive++;
               if (nlive <= 1) begin
                  rep.status = mrrp_pkg::ST_LAST;
               end else begin
                  live_of[rd] = 1'b0;
                  free_unreachable();
               end
            end
         end
         default: rep.status = mrrp_pkg::ST_BAD_SLOT;  // undefined func codes
      endcase
      if (slot_live(rd)) rep.readable = mrrp_pkg::CNT_W'(reach_of(rd));
      if (fn == mrrp_pkg::FN_PUSH) rep.offset = mrrp_pkg::OFS_W'(tail);
      else if (slot_live(rd))      rep.offset = mrrp_pkg::OFS_W'(head_of[rd] % c);
      rep.used_bytes = ring_fill;
      return rep;
   endfunction

   // random slot in the wanted state, -1 if none
   function automatic int pick_slot(input bit want_live);
      int cand [$];
      int r;
      for (r = 0; r < mrrp_pkg::NUM_READERS; r++)
         if (live_of[r] == want_live) cand.push_back(r);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
   endfunction

   // ------------------------------------------------------------------
   // Command sender: one word per call, bursts with random gaps between while
   // sender_idles is set. valid stays high across a burst; it drops when a gap starts or sending stops.
   // ------------------------------------------------------------------
   task automatic send_cmd(
      input logic [mrrp_pkg::FUNC_W-1:0] fn,
      input logic [mrrp_pkg::SLOT_W-1:0] rd,
      input logic [mrrp_pkg::SLOT_W-1:0] src,
      input logic [mrrp_pkg::CNT_W-1:0]  cnt
   );
      req_valid         <= 1'b1;
      req_func          <= fn;
      req_reader        <= rd;
      req_source_reader <= src;
      req_count         <= cnt;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      // accepted at this edge; model steps in accept order
      ring_replies.push_back(apply_ring_cmd(fn, rd, src, cnt));
      words_sent++;
      if (sender_idles) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Capacity write: only with the pipe empty. Model clears the ring,
   // keeps active slots, and clamps the value into 1..RING_BYTES.
   task automatic write_capacity(input logic [mrrp_pkg::CNT_W-1:0] value);
      stop_sending();
      while (ring_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (value == 0)                           ring_cap = mrrp_pkg::CNT_W'(1);
      else if (value > mrrp_pkg::RING_BYTES)    ring_cap = mrrp_pkg::CAP_MAX;
      else                                      ring_cap = value;
      empty_ring();
      caps_written++;
   endtask

   // Mostly legal traffic built from the model state so acks, dups and
   // removes land on live slots; the rest is noise over the full fields.
   task automatic send_random_cmd(input int noise_pct);
      logic [mrrp_pkg::FUNC_W-1:0] fn;
      logic [mrrp_pkg::SLOT_W-1:0] rd, src;
      logic [mrrp_pkg::CNT_W-1:0]  cnt;
      int a, b, room, reach;
      fn  = mrrp_pkg::FN_PEEK;
      rd  = mrrp_pkg::SLOT_W'($urandom);
      src = mrrp_pkg::SLOT_W'($urandom);
      cnt = mrrp_pkg::CNT_W'($urandom_range(0, 8191));
      if ($urandom_range(0, 99) < noise_pct) begin
         fn = mrrp_pkg::FUNC_W'($urandom_range(0, 7));
         if ($urandom_range(0, 1))
            cnt = mrrp_pkg::CNT_W'($urandom_range(0, int'(ring_cap) + 2));
      end else begin
         a     = pick_slot(1'b1);
         b     = pick_slot(1'b0);
         room  = int'(ring_cap) - int'(ring_fill);
         reach = int'(reach_of(a));
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               fn  = mrrp_pkg::FN_PUSH;
               cnt = ($urandom_range(0, 3) == 0)
                        ? mrrp_pkg::CNT_W'(room)
                        : mrrp_pkg::CNT_W'($urandom_range(0, room));
            end
            3, 4, 5, 9: begin
               fn  = mrrp_pkg::FN_ACK;
               rd  = mrrp_pkg::SLOT_W'(a);
               cnt = ($urandom_range(0, 3) == 0)
                        ? mrrp_pkg::CNT_W'(reach)
                        : mrrp_pkg::CNT_W'($urandom_range(0, reach));
            end
            6: begin
               fn = mrrp_pkg::FN_PEEK;
               rd = mrrp_pkg::SLOT_W'(a);
            end
            7: begin
               if (b >= 0) begin
                  fn  = mrrp_pkg::FN_DUP;
                  rd  = mrrp_pkg::SLOT_W'(b);
                  src = mrrp_pkg::SLOT_W'(a);
               end else begin
                  fn = mrrp_pkg::FN_REM;
                  rd = mrrp_pkg::SLOT_W'(a);
               end
            end
            default: begin
               fn = mrrp_pkg::FN_REM;
               rd = mrrp_pkg::SLOT_W'(a);
            end
         endcase
      end
      send_cmd(fn, rd, src, cnt);
   endtask

   // ------------------------------------------------------------------
   // Result side: stall pattern switches to a random mode whenever its countdown runs out;
   // the hold-off process can force stall on for a long stretch.
   // ------------------------------------------------------------------
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(32, 256);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_LIGHT: rsp_stall <= hold_on || ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= hold_on || ($urandom_range(0, 3) != 0);
         STALL_RUNS:  rsp_stall <= hold_on || stall_left[2];
         default:     rsp_stall <= hold_on;
      endcase
   end

   // long hold-off, counted here so the sender keeps offering meanwhile
   initial begin
      wait (hold_request);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   task automatic report_bad(input string what, input ring_reply_type want,
                             input ring_reply_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display({"[%0t] %s: exp st=%0d rd=%0d ofs=%0d used=%0d, ",
                   "got st=%0d rd=%0d ofs=%0d used=%0d"},
                  $realtime, what, want.status, want.readable, want.offset,
                  want.used_bytes, got.status, got.readable, got.offset, got.used_bytes);
   endtask

   // compare each accepted result word with the oldest owed word
   always @(posedge clock) begin
      ring_reply_type got, want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = {rsp_status, rsp_readable, rsp_offset, rsp_used_bytes};
         words_checked++;
         status_seen[got.status]++;
         if (ring_replies.size() == 0) begin
            report_bad("result word with nothing owed", '0, got);
         end else begin
            want = ring_replies.pop_front();
            if (got.status !== want.status || got.readable !== want.readable ||
                got.offset !== want.offset || got.used_bytes !== want.used_bytes)
               report_bad("result word mismatch", want, got);
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("watchdog: %0d cycles, %0d words still owed", cycle_count,
               ring_replies.size());
      $display("multi_reader_ring_pointers regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Corner cases at the reset capacity (4096, only slot 0 live).
   task automatic test_directed_cases();
      send_cmd(mrrp_pkg::FN_PEEK, 0, 0, 0);
      send_cmd(mrrp_pkg::FN_PEEK, 7, 7, 0);      // peek on a dead slot
      send_cmd(mrrp_pkg::FN_ACK,  0, 0, 1);      // ack past readable on empty ring
      send_cmd(mrrp_pkg::FN_ACK,  5, 0, 0);      // ack on a dead slot
      send_cmd(mrrp_pkg::FN_PUSH, 0, 0, 0);      // zero-byte push
      send_cmd(mrrp_pkg::FN_PUSH, 0, 0, 4096);   // fill the ring exactly
      send_cmd(mrrp_pkg::FN_PUSH, 0, 0, 1);      // no space
      send_cmd(mrrp_pkg::FN_PUSH, 7, 7, 8191);   // all count bits, no space
      send_cmd(mrrp_pkg::FN_REM,  0, 0, 0);      // removing the last reader
      send_cmd(mrrp_pkg::FN_DUP,  0, 0, 0);      // dup onto a live slot
      send_cmd(mrrp_pkg::FN_DUP,  3, 4, 0);      // dup from a dead slot
      send_cmd(mrrp_pkg::FN_DUP,  7, 0, 0);
      send_cmd(mrrp_pkg::FN_ACK,  0, 0, 0);      // zero-byte ack
      send_cmd(mrrp_pkg::FN_ACK,  0, 0, 4096);   // head laps to start: starved
      send_cmd(mrrp_pkg::FN_PEEK, 0, 0, 0);      // starved reader on full ring
      send_cmd(mrrp_pkg::FN_ACK,  7, 0, 4095);   // oldest reader moves, frees bytes
      send_cmd(mrrp_pkg::FN_ACK,  0, 0, 1);
      send_cmd(mrrp_pkg::FN_PUSH, 0, 0, 4095);   // refill clears starved flags
      send_cmd(mrrp_pkg::FN_REM,  7, 0, 0);      // remove frees unreachable bytes
      send_cmd(mrrp_pkg::FUNC_W'(mrrp_pkg::FN_REM + 1), 0, 7, 4095);  // undefined codes
      send_cmd(mrrp_pkg::FUNC_W'(mrrp_pkg::FN_REM + 2), 7, 0, 0);
      send_cmd(mrrp_pkg::FUNC_W'(mrrp_pkg::FN_REM + 3), 3, 5, 8191);
      send_cmd(mrrp_pkg::FN_REM,  6, 0, 0);      // remove a dead slot
      send_cmd(mrrp_pkg::FN_DUP,  1, 0, 0);
      send_cmd(mrrp_pkg::FN_ACK,  1, 0, 4095);
   endtask

   // Random traffic across capacities: extremes, clamped values, tiny rings
   // that wrap and fill constantly, and a couple of random sizes.
   task automatic test_capacity_phases();
      logic [mrrp_pkg::CNT_W-1:0] caps [12];
      int p, i;
      caps = '{13'd4096, 13'd1, 13'd0, 13'd2, 13'd3, 13'd8191,
               13'd7, 13'd16, 13'd4097, 13'd64, 13'd0, 13'd0};
      caps[10] = mrrp_pkg::CNT_W'($urandom_range(17, 600));
      caps[11] = mrrp_pkg::CNT_W'($urandom_range(1, 4096));
      for (p = 0; p < 12; p++) begin
         write_capacity(caps[p]);
         sender_idles = (p % 3 != 2);   // every third phase runs back to back
         for (i = 0; i < PHASE_WORDS; i++) send_random_cmd(NOISE_PCT);
      end
      sender_idles = 1'b1;
   endtask

   // Hold the result side off while words keep coming so the block fills
   // its output register and stalls the command side.
   task automatic test_backpressure();
      int i;
      write_capacity(13'd64);
      sender_idles = 1'b0;
      hold_request = 1'b1;
      for (i = 0; i < 48; i++) send_random_cmd(5);
      sender_idles = 1'b1;
   endtask

   initial begin
      ring_cap = mrrp_pkg::CAP_MAX;
      empty_ring();
      for (int r = 0; r < mrrp_pkg::NUM_READERS; r++) live_of[r] = (r == 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_capacity_phases();
      test_backpressure();

      // drain: wait for every owed word, bounded, then settle
      stop_sending();
      begin
         int waited;
         waited = 0;
         while (ring_replies.size() != 0 && waited < 20 * HOLD_CYCLES) begin
            @(posedge clock);
            waited++;
         end
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ring_replies.size() != 0) begin
         $display("%0d expected result words never arrived", ring_replies.size());
         mismatches += ring_replies.size();
      end

      $display("covered %0d command words over %0d capacity writes, with a %0d-cycle hold-off",
               words_sent, caps_written, HOLD_CYCLES);
      $display("results checked %0d: ok %0d, no space %0d, too big %0d, bad slot %0d, last %0d",
               words_checked, status_seen[mrrp_pkg::ST_OK],
               status_seen[mrrp_pkg::ST_NO_SPACE], status_seen[mrrp_pkg::ST_TOO_BIG],
               status_seen[mrrp_pkg::ST_BAD_SLOT], status_seen[mrrp_pkg::ST_LAST]);
      if (mismatches == 0) begin
         $display("multi_reader_ring_pointers regression: pass");
      end else begin
         $display("%0d failures", mismatches);
         $display("multi_reader_ring_pointers regression: fail");
      end
      $finish;
   end

endmodule
